// ----- rtl/mesh_face_neighbor_finder_assert.svh -----
// Assertion macros for the mesh face neighbor finder.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef MESH_FACE_NEIGHBOR_FINDER_ASSERT_SVH
`define MESH_FACE_NEIGHBOR_FINDER_ASSERT_SVH

// Check a condition at every rising clock edge outside reset.
`define MFNF_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define MFNF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/mfnf_pkg.sv -----
// Shared types, codes and face tables for the mesh face neighbor finder.
// No dependencies.
package mfnf_pkg;

	localparam int VID_W   = 20;
	localparam int IDX_W   = 10;
	localparam int INNER_W = 11;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] KIND_HEX   = 2'd0;
	localparam logic [1:0] KIND_PRISM = 2'd1;

	typedef struct packed {
		logic [1:0]       operation;
		logic [1:0]       element_kind;
		logic [3:0]       vertex_count;
		logic [VID_W-1:0] vertex_a;
		logic [VID_W-1:0] vertex_b;
		logic [VID_W-1:0] vertex_c;
		logic [VID_W-1:0] vertex_d;
		logic [VID_W-1:0] vertex_e;
		logic [VID_W-1:0] vertex_f;
		logic [VID_W-1:0] vertex_g;
		logic [VID_W-1:0] vertex_h;
		logic [IDX_W-1:0] query_index;
	} item_t;

	typedef struct packed {
		logic [IDX_W-1:0] element_number;
		logic [2:0]       face_slot;
		logic [IDX_W-1:0] neighbor_number;
		logic             found;
		logic             last_of_run;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic       rd_en;
		logic       wr_en;
		logic       capture;
		logic [2:0] slot;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       hit;
		logic [1:0] kind;
	} dp_stat_t;

	typedef logic [3:0][2:0] face_pos_t;

	// Vertex positions of one face; entry 0 is the first face vertex.
	function automatic face_pos_t face_pos(input logic prism, input logic [2:0] slot);
		face_pos_t p;
		p = '0;
		if (prism) begin
			unique case (slot)
				3'd0: p = {3'd0, 3'd2, 3'd1, 3'd0};
				3'd1: p = {3'd0, 3'd5, 3'd4, 3'd3};
				3'd2: p = {3'd3, 3'd4, 3'd1, 3'd0};
				3'd3: p = {3'd4, 3'd5, 3'd2, 3'd1};
				3'd4: p = {3'd5, 3'd3, 3'd0, 3'd2};
				default: p = '0;
			endcase
		end else begin
			unique case (slot)
				3'd0: p = {3'd3, 3'd2, 3'd1, 3'd0};
				3'd1: p = {3'd7, 3'd6, 3'd5, 3'd4};
				3'd2: p = {3'd4, 3'd5, 3'd1, 3'd0};
				3'd3: p = {3'd5, 3'd6, 3'd2, 3'd1};
				3'd4: p = {3'd6, 3'd7, 3'd3, 3'd2};
				3'd5: p = {3'd7, 3'd4, 3'd0, 3'd3};
				default: p = '0;
			endcase
		end
		return p;
	endfunction

	// Triangle faces of a prism have three vertices, all others four.
	function automatic logic [2:0] face_size(input logic prism, input logic [2:0] slot);
		return (prism && slot < 3'd2) ? 3'd3 : 3'd4;
	endfunction

endpackage

// ----- rtl/mesh_face_neighbor_finder.sv -----
// Top level of the mesh face neighbor finder.
// Depends on mfnf_pkg, mfnf_ctrl and mfnf_datapath.

// Stores up to MAX_ELEMENTS mesh elements (kind, vertex count, eight vertex ids)
// in one row memory with separate read and write addresses, one row per
// element, and answers face neighbor queries over them. A load or a clear gives
// no result. A query on an inner hex or prism scans the loaded elements once per
// face up to the first that shares the face, reading each other element from
// memory and then testing it, and skipping itself; it gives one result per
// face. A query on an inner element of another kind, or on an index beyond the
// loaded elements, gives a single not-found result. A query on a boundary element
// walks the faces of the inner elements one by one: it reads the kind of each
// inner element, checks each face against the queried element and, when that
// passes, scans for the first element that shares the face; it gives a single
// result, found when that first element is the queried one. A new item is taken
// only between queries; a finished result waits in the output register while
// loads go on.
// Configuration: write inner_count only while the block is idle.
module mesh_face_neighbor_finder #(
	parameter int MAX_ELEMENTS   = 1024,
	parameter int VERTEX_ID_BITS = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  mfnf_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output mfnf_pkg::result_t             result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mfnf_pkg::INNER_W-1:0]  cfg_data
);
	localparam int IW = $clog2(MAX_ELEMENTS);

	mfnf_pkg::dp_cmd_t  cmd;
	mfnf_pkg::dp_stat_t stat;
	logic [IW-1:0]      rd_addr;
	logic [IW-1:0]      wr_addr;

	// sequence loads, scans and result transfers
	mfnf_ctrl #(
		.MAX_ELEMENTS(MAX_ELEMENTS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.stat        (stat)
	);

	// hold the element rows and test each row read from memory against one face
	mfnf_datapath #(
		.MAX_ELEMENTS  (MAX_ELEMENTS),
		.VERTEX_ID_BITS(VERTEX_ID_BITS)
	) u_datapath (
		.clk    (clk),
		.item   (item),
		.cmd    (cmd),
		.rd_addr(rd_addr),
		.wr_addr(wr_addr),
		.stat   (stat)
	);

endmodule

// ----- rtl/mfnf_datapath.sv -----
// Element store, face vertex selection and shared-vertex face test.
// Depends on mfnf_pkg; driven by mfnf_ctrl.
module mfnf_datapath #(
	parameter int MAX_ELEMENTS   = 1024,
	parameter int VERTEX_ID_BITS = 20
) (
	input  logic                              clk,
	input  mfnf_pkg::item_t                   item,
	input  mfnf_pkg::dp_cmd_t                 cmd,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   rd_addr,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]   wr_addr,
	output mfnf_pkg::dp_stat_t                stat
);
	localparam int VB = VERTEX_ID_BITS;
	localparam int RW = 6 + 8 * VB;

	logic [RW-1:0] mem [MAX_ELEMENTS];
	logic [RW-1:0] rd_q;
	logic [RW-1:0] erow_q;
	logic [RW-1:0] wrow;

	logic [7:0][VB-1:0] rverts;
	logic [7:0][VB-1:0] everts;
	logic [3:0][VB-1:0] fv;
	logic [3:0]         rcount;
	logic [3:0]         cnt;
	logic [2:0]         fsize;
	logic               prism;
	mfnf_pkg::face_pos_t pos;
	logic [3:0]         got;
	logic               taken;
	logic               hit;

	function automatic logic [VB-1:0] vid(input logic [mfnf_pkg::VID_W-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[VB-1:0];
	endfunction

	assign wrow = {item.element_kind, item.vertex_count,
		vid(item.vertex_h), vid(item.vertex_g), vid(item.vertex_f), vid(item.vertex_e),
		vid(item.vertex_d), vid(item.vertex_c), vid(item.vertex_b), vid(item.vertex_a)};

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wrow;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.capture) begin
			erow_q <= rd_q;
		end
	end

	assign rverts = rd_q[8*VB-1:0];
	assign rcount = rd_q[8*VB+3:8*VB];
	assign everts = erow_q[8*VB-1:0];
	assign prism  = (erow_q[RW-1:RW-2] == mfnf_pkg::KIND_PRISM);
	assign pos    = mfnf_pkg::face_pos(prism, cmd.slot);
	assign fsize  = mfnf_pkg::face_size(prism, cmd.slot);
	assign cnt    = (rcount > 4'd8) ? 4'd8 : rcount;

	always_comb begin
		for (int m = 0; m < 4; m++) begin
			fv[m] = everts[pos[m]];
		end
	end

	// Greedy match: each stored vertex claims the first open face vertex it equals.
	always_comb begin
		got = '0;
		taken = 1'b0;
		for (int j = 0; j < 8; j++) begin
			taken = 1'b0;
			for (int m = 0; m < 4; m++) begin
				if (!taken && (4'(j) < cnt) && (3'(m) < fsize) && !got[m]
					&& rverts[j] == fv[m]) begin
					got[m] = 1'b1;
					taken = 1'b1;
				end
			end
		end
		hit = 1'b1;
		for (int m = 0; m < 4; m++) begin
			if ((3'(m) < fsize) && !got[m]) begin
				hit = 1'b0;
			end
		end
	end

	assign stat.hit  = hit;
	assign stat.kind = rd_q[RW-1:RW-2];

endmodule

// ----- rtl/mfnf_ctrl.sv -----
// Query sequencer: element count, scan counters and the result register.
// Depends on mfnf_pkg and the assertion macro header; drives mfnf_datapath.
`include "mesh_face_neighbor_finder_assert.svh"
module mfnf_ctrl #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  mfnf_pkg::item_t                   item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output mfnf_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mfnf_pkg::INNER_W-1:0]      cfg_data,
	output mfnf_pkg::dp_cmd_t                 cmd,
	output logic [$clog2(MAX_ELEMENTS)-1:0]   rd_addr,
	output logic [$clog2(MAX_ELEMENTS)-1:0]   wr_addr,
	input  mfnf_pkg::dp_stat_t                stat
);
	localparam int IW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int WW = (CW > mfnf_pkg::INNER_W) ? CW : mfnf_pkg::INNER_W;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_QRD   = 11'b00000000010,
		S_QCHK  = 11'b00000000100,
		S_FSET  = 11'b00000001000,
		S_SRD   = 11'b00000010000,
		S_SCHK  = 11'b00000100000,
		S_BJRD  = 11'b00001000000,
		S_BJCHK = 11'b00010000000,
		S_BQRD  = 11'b00100000000,
		S_BQCHK = 11'b01000000000,
		S_EMIT  = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [CW-1:0]                   loaded_q;
	logic [mfnf_pkg::INNER_W-1:0]    inner_count_q;
	logic [mfnf_pkg::IDX_W-1:0]      q_q;
	logic [CW-1:0]                   k_q;
	logic [CW-1:0]                   j_q;
	logic [2:0]                      s_q;
	logic [2:0]                      nf_q;
	logic                            bmode_q;
	logic [2:0]                      res_slot_q;
	logic [WW-1:0]                   res_nb_q;
	logic                            res_found_q;
	logic                            res_last_q;
	logic                            out_v_q;
	mfnf_pkg::result_t               result_q;

	logic [WW-1:0] loaded_w, inner_w, q_w, k_w, j_w, self_w;
	logic          accept;
	logic          last_face;
	logic          emit_go;

	assign loaded_w  = WW'(loaded_q);
	assign inner_w   = (WW'(inner_count_q) < loaded_w) ? WW'(inner_count_q) : loaded_w;
	assign q_w       = WW'(q_q);
	assign k_w       = WW'(k_q);
	assign j_w       = WW'(j_q);
	assign self_w    = bmode_q ? j_w : q_w;
	assign last_face = (s_q + 3'd1 == nf_q);
	assign emit_go   = (state_q == S_EMIT) && (!out_v_q || !result_stall);

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign cfg_ready  = 1'b1;
	assign result_valid = out_v_q;
	assign result       = result_q;

	assign wr_addr = loaded_q[IW-1:0];

	always_comb begin
		logic [WW-1:0] qa;
		qa = q_w;
		cmd.wr_en   = accept && (item.operation == mfnf_pkg::OP_LOAD)
			&& (loaded_q < CW'(MAX_ELEMENTS));
		cmd.rd_en   = 1'b0;
		cmd.capture = (state_q == S_QCHK) || (state_q == S_BJCHK);
		cmd.slot    = s_q;
		rd_addr     = qa[IW-1:0];
		unique case (state_q)
			S_QRD, S_BQRD: begin
				cmd.rd_en = 1'b1;
			end
			S_SRD: begin
				cmd.rd_en = (k_w < loaded_w) && (k_w != self_w);
				rd_addr   = k_q[IW-1:0];
			end
			S_BJRD: begin
				cmd.rd_en = (j_w < inner_w);
				rd_addr   = j_q[IW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			loaded_q      <= '0;
			inner_count_q <= '0;
			out_v_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				inner_count_q <= cfg_data;
			end
			// load a new result, or drop the old one once it transfers
			if (emit_go) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !result_stall) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (item.operation == mfnf_pkg::OP_LOAD) begin
							if (cmd.wr_en) begin
								loaded_q <= loaded_q + CW'(1);
							end
						end else if (item.operation == mfnf_pkg::OP_CLEAR) begin
							loaded_q <= '0;
						end else if (item.operation == mfnf_pkg::OP_QUERY) begin
							q_q     <= item.query_index;
							bmode_q <= 1'b0;
							if (WW'(item.query_index) >= loaded_w) begin
								res_slot_q  <= '0;
								res_nb_q    <= '0;
								res_found_q <= 1'b0;
								res_last_q  <= 1'b1;
								state_q     <= S_EMIT;
							end else begin
								state_q <= S_QRD;
							end
						end else begin
						end
					end
				end
				S_QRD: state_q <= S_QCHK;
				S_QCHK: begin
					if (q_w < inner_w) begin
						priority if (stat.kind == mfnf_pkg::KIND_HEX) begin
							nf_q <= 3'd6; s_q <= '0; state_q <= S_FSET;
						end else if (stat.kind == mfnf_pkg::KIND_PRISM) begin
							nf_q <= 3'd5; s_q <= '0; state_q <= S_FSET;
						end else begin
							res_slot_q  <= '0;
							res_nb_q    <= '0;
							res_found_q <= 1'b0;
							res_last_q  <= 1'b1;
							state_q     <= S_EMIT;
						end
					end else begin
						bmode_q <= 1'b1;
						j_q     <= '0;
						state_q <= S_BJRD;
					end
				end
				S_FSET: begin
					k_q     <= '0;
					state_q <= S_SRD;
				end
				S_SRD: begin
					priority if (k_w >= loaded_w) begin
						if (bmode_q) begin
							if (last_face) begin
								j_q <= j_q + CW'(1); state_q <= S_BJRD;
							end else begin
								s_q <= s_q + 3'd1; state_q <= S_BQRD;
							end
						end else begin
							res_slot_q  <= s_q;
							res_nb_q    <= '0;
							res_found_q <= 1'b0;
							res_last_q  <= last_face;
							state_q     <= S_EMIT;
						end
					end else if (k_w == self_w) begin
						k_q <= k_q + CW'(1);
					end else begin
						state_q <= S_SCHK;
					end
				end
				S_SCHK: begin
					if (stat.hit) begin
						if (bmode_q) begin
							priority if (k_w == q_w) begin
								res_slot_q  <= '0;
								res_nb_q    <= j_w;
								res_found_q <= 1'b1;
								res_last_q  <= 1'b1;
								state_q     <= S_EMIT;
							end else if (last_face) begin
								j_q <= j_q + CW'(1); state_q <= S_BJRD;
							end else begin
								s_q <= s_q + 3'd1; state_q <= S_BQRD;
							end
						end else begin
							res_slot_q  <= s_q;
							res_nb_q    <= k_w;
							res_found_q <= 1'b1;
							res_last_q  <= last_face;
							state_q     <= S_EMIT;
						end
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= S_SRD;
					end
				end
				S_BJRD: begin
					if (j_w >= inner_w) begin
						res_slot_q  <= '0;
						res_nb_q    <= '0;
						res_found_q <= 1'b0;
						res_last_q  <= 1'b1;
						state_q     <= S_EMIT;
					end else begin
						state_q <= S_BJCHK;
					end
				end
				S_BJCHK: begin
					priority if (stat.kind == mfnf_pkg::KIND_HEX) begin
						nf_q <= 3'd6; s_q <= '0; state_q <= S_BQRD;
					end else if (stat.kind == mfnf_pkg::KIND_PRISM) begin
						nf_q <= 3'd5; s_q <= '0; state_q <= S_BQRD;
					end else begin
						j_q <= j_q + CW'(1); state_q <= S_BJRD;
					end
				end
				S_BQRD: state_q <= S_BQCHK;
				S_BQCHK: begin
					priority if (stat.hit) begin
						k_q <= '0; state_q <= S_SRD;
					end else if (last_face) begin
						j_q <= j_q + CW'(1); state_q <= S_BJRD;
					end else begin
						s_q <= s_q + 3'd1; state_q <= S_BQRD;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						result_q.element_number  <= q_q;
						result_q.face_slot       <= res_slot_q;
						result_q.neighbor_number <= res_nb_q[mfnf_pkg::IDX_W-1:0];
						result_q.found           <= res_found_q;
						result_q.last_of_run     <= res_last_q;
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else begin
							s_q     <= s_q + 3'd1;
							state_q <= S_FSET;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MFNF_ASSERT_NEXT(a_result_kept, out_v_q && result_stall, out_v_q, "stalled result lost")
	`MFNF_ASSERT(a_scan_bound, state_q != S_SCHK || k_q < loaded_q, "scan beyond loaded elements")
	`MFNF_ASSERT_NEXT(a_query_start, accept && item.operation == mfnf_pkg::OP_QUERY,
		state_q == S_QRD || state_q == S_EMIT, "query did not start")

endmodule

// ----- bench/tb_mesh_face_neighbor_finder.sv -----
// Self-checking bench for the mesh face neighbor finder: loads small meshes,
// runs neighbor queries and compares every result with an in-bench predictor.
// Depends on mfnf_pkg and the mesh_face_neighbor_finder RTL.
`timescale 1ns / 100ps

import mfnf_pkg::*;

// Tracks the element store the same way the block does and keeps the queue
// of face-neighbor results still owed by the block.
class neighbor_scoreboard;
	localparam int STORE_DEPTH = 1024;

	int unsigned inner_cnt;
	int unsigned loaded;
	logic [VID_W-1:0] verts [STORE_DEPTH*8];
	logic [1:0] kinds [STORE_DEPTH];
	logic [3:0] counts [STORE_DEPTH];
	result_t owed [$];
	int errors;
	int checked;
	int hex_tab [24] = '{0,1,2,3, 4,5,6,7, 0,1,5,4, 1,2,6,5, 2,3,7,6, 3,0,4,7};
	int prism_tab [20] = '{0,1,2,0, 3,4,5,0, 0,1,4,3, 1,2,5,4, 2,0,3,5};

	function new();
		inner_cnt = 0;
		loaded = 0;
		errors = 0;
		checked = 0;
	endfunction

	function void set_inner(logic [INNER_W-1:0] v);
		inner_cnt = v;
	endfunction

	function int face_total(int e);
		if (kinds[e] == KIND_HEX) return 6;
		if (kinds[e] == KIND_PRISM) return 5;
		return 0;
	endfunction

	// Gather the vertex ids of one face of element e.
	function int face_ids(int e, int s, output logic [VID_W-1:0] fv [4]);
		int n;
		n = (kinds[e] == KIND_PRISM && s < 2) ? 3 : 4;
		for (int m = 0; m < 4; m++) begin
			if (kinds[e] == KIND_PRISM)
				fv[m] = verts[e*8 + prism_tab[s*4+m]];
			else
				fv[m] = verts[e*8 + hex_tab[s*4+m]];
		end
		return n;
	endfunction

	// Each stored vertex may claim only one face vertex.
	function bit holds(int k, logic [VID_W-1:0] fv [4], int n);
		bit got [4];
		int cnt;
		for (int m = 0; m < 4; m++) got[m] = 0;
		cnt = (counts[k] > 8) ? 8 : counts[k];
		for (int j = 0; j < cnt; j++) begin
			for (int m = 0; m < n; m++) begin
				if (!got[m] && verts[k*8+j] == fv[m]) begin
					got[m] = 1;
					break;
				end
			end
		end
		for (int m = 0; m < n; m++)
			if (!got[m]) return 0;
		return 1;
	endfunction

	function bit first_hit(int self, logic [VID_W-1:0] fv [4], int n, output int hit);
		hit = 0;
		for (int k = 0; k < loaded; k++) begin
			if (k != self && holds(k, fv, n)) begin
				hit = k;
				return 1;
			end
		end
		return 0;
	endfunction

	function void owe(int e, int slot, int nb, bit fnd, bit last);
		result_t r;
		r.element_number  = e[IDX_W-1:0];
		r.face_slot       = slot[2:0];
		r.neighbor_number = fnd ? nb[IDX_W-1:0] : '0;
		r.found           = fnd;
		r.last_of_run     = last;
		owed.push_back(r);
	endfunction

	function void note_item(item_t it);
		int unsigned inner;
		int q;
		int nf;
		int n;
		int hit;
		bit ok;
		logic [VID_W-1:0] fv [4];
		inner = (inner_cnt < loaded) ? inner_cnt : loaded;
		case (it.operation)
			OP_LOAD: begin
				if (loaded < STORE_DEPTH) begin
					kinds[loaded] = it.element_kind;
					counts[loaded] = it.vertex_count;
					verts[loaded*8+0] = it.vertex_a;
					verts[loaded*8+1] = it.vertex_b;
					verts[loaded*8+2] = it.vertex_c;
					verts[loaded*8+3] = it.vertex_d;
					verts[loaded*8+4] = it.vertex_e;
					verts[loaded*8+5] = it.vertex_f;
					verts[loaded*8+6] = it.vertex_g;
					verts[loaded*8+7] = it.vertex_h;
					loaded++;
				end
			end
			OP_CLEAR: loaded = 0;
			OP_QUERY: begin
				q = it.query_index;
				if (q >= loaded) begin
					owe(q, 0, 0, 0, 1);
				end else if (q < inner) begin
					nf = face_total(q);
					if (nf == 0) owe(q, 0, 0, 0, 1);
					for (int s = 0; s < nf; s++) begin
						n = face_ids(q, s, fv);
						ok = first_hit(q, fv, n, hit);
						owe(q, s, hit, ok, s + 1 == nf);
					end
				end else begin
					// boundary: first inner element that sees q across one of its faces
					ok = 0;
					for (int j = 0; j < inner && !ok; j++) begin
						nf = face_total(j);
						for (int s = 0; s < nf && !ok; s++) begin
							n = face_ids(j, s, fv);
							if (holds(q, fv, n) && first_hit(j, fv, n, hit) && hit == q) begin
								owe(q, 0, j, 1, 1);
								ok = 1;
							end
						end
					end
					if (!ok) owe(q, 0, 0, 0, 1);
				end
			end
			default: ;
		endcase
	endfunction

	function void check_result(result_t got);
		result_t exp_r;
		if (owed.size() == 0) begin
			$display("%0t: unexpected result %p", $time, got);
			errors++;
			return;
		end
		exp_r = owed.pop_front();
		checked++;
		if (got.element_number !== exp_r.element_number)
			report("element_number", exp_r.element_number, got.element_number);
		if (got.face_slot !== exp_r.face_slot)
			report("face_slot", exp_r.face_slot, got.face_slot);
		if (got.neighbor_number !== exp_r.neighbor_number)
			report("neighbor_number", exp_r.neighbor_number, got.neighbor_number);
		if (got.found !== exp_r.found)
			report("found", exp_r.found, got.found);
		if (got.last_of_run !== exp_r.last_of_run)
			report("last_of_run", exp_r.last_of_run, got.last_of_run);
	endfunction

	function void report(string field, logic [IDX_W-1:0] e, logic [IDX_W-1:0] a);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
		errors++;
	endfunction
endclass

module tb_mesh_face_neighbor_finder;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_ODD   = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam logic [VID_W-1:0] VID_MAX = '1;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	item_t item;
	logic result_valid;
	logic result_stall;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [INNER_W-1:0] cfg_data;

	neighbor_scoreboard sb;
	bit burst;              // when set, both sides run with no gaps
	bit took;               // a result transferred at the last rising edge
	int hold_left;
	int queries_sent;
	int loads_sent;
	logic [VID_W-1:0] pool [12];

	mesh_face_neighbor_finder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int draw_gap();
		return burst ? 0 : $urandom_range(0, 16);
	endfunction

	// Result side: hold stall for a randomly drawn gap before each transfer.
	always @(negedge clk) begin
		int h;
		h = took ? draw_gap() : hold_left;
		if (h > 0) begin
			result_stall <= 1'b1;
			hold_left <= h - 1;
		end else begin
			result_stall <= 1'b0;
			hold_left <= 0;
		end
	end

	always @(posedge clk) begin
		took <= arst_n && result_valid && !result_stall;
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result);
		end
	end

	// Idle for a drawn gap, then present the item until the block takes it.
	task automatic send(item_t it);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
		if (it.operation == OP_QUERY) queries_sent++;
		if (it.operation == OP_LOAD) loads_sent++;
		@(negedge clk);
	endtask

	// Drain all owed results, then give a lone load or clear time to finish.
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_inner(logic [INNER_W-1:0] v);
		settle();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_inner(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t rand_item();
		logic [191:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return item_t'(bits[$bits(item_t)-1:0]);
	endfunction

	function automatic item_t elem(logic [1:0] kind, logic [3:0] cnt,
			logic [VID_W-1:0] a, logic [VID_W-1:0] b, logic [VID_W-1:0] c,
			logic [VID_W-1:0] d, logic [VID_W-1:0] e, logic [VID_W-1:0] f,
			logic [VID_W-1:0] g, logic [VID_W-1:0] h);
		item_t it;
		it = '0;
		it.operation = OP_LOAD;
		it.element_kind = kind;
		it.vertex_count = cnt;
		{it.vertex_a, it.vertex_b, it.vertex_c, it.vertex_d} = {a, b, c, d};
		{it.vertex_e, it.vertex_f, it.vertex_g, it.vertex_h} = {e, f, g, h};
		it.query_index = IDX_W'($urandom);
		return it;
	endfunction

	function automatic item_t ask(int idx);
		item_t it;
		it = rand_item();
		it.operation = OP_QUERY;
		it.query_index = idx[IDX_W-1:0];
		return it;
	endfunction

	function automatic item_t plain(logic [1:0] op);
		item_t it;
		it = rand_item();
		it.operation = op;
		return it;
	endfunction

	function automatic logic [VID_W-1:0] pick();
		return pool[$urandom_range(0, 11)];
	endfunction

	// Random element whose vertices come from the shared pool, so faces meet.
	function automatic item_t pool_elem(logic [1:0] kind);
		return elem(kind, (kind == KIND_PRISM) ? 4'd6 : 4'd8, pick(), pick(), pick(),
			pick(), pick(), pick(), pick(), pick());
	endfunction

	// Boundary element built from one face of an earlier element, shuffled.
	function automatic item_t face_elem(int src);
		logic [VID_W-1:0] fv [4];
		int n;
		int s;
		item_t it;
		s = $urandom_range(0, 5);
		if (sb.kinds[src] == KIND_PRISM) s = $urandom_range(0, 4);
		n = sb.face_ids(src, s, fv);
		fv.shuffle();
		if (n == 3 && fv[3] == sb.verts[src*8 + 0]) begin
			// the branch only sets n to three again; the ids stay in shuffled order
			n = 3;
		end
		it = elem(KIND_OTHER, 4'd4, fv[0], fv[1], fv[2], fv[3],
			VID_W'($urandom), VID_W'($urandom), VID_W'($urandom), VID_W'($urandom));
		return it;
	endfunction

	initial begin
		int n_elems;
		int n_q;
		int phases;
		int r;
		item_t it;
		sb = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		hold_left = 0;
		burst = 0;
		queries_sent = 0;
		loads_sent = 0;
		phases = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: two hexes sharing a face, two prisms, a boundary quad, odd kinds
		write_inner(11'd4);
		send(elem(KIND_HEX, 4'd8, 20'd0, 20'd1, 20'd2, 20'd3,
			20'd4, 20'd5, 20'd6, VID_MAX));
		send(elem(KIND_HEX, 4'd8, 20'd4, 20'd5, 20'd6, VID_MAX,
			20'd10, 20'd11, 20'd12, 20'd13));
		send(elem(KIND_PRISM, 4'd6, 20'd2, 20'd1, 20'd1, 20'd10,
			20'd11, 20'd12, 20'd0, 20'd0));
		send(elem(KIND_PRISM, 4'd6, 20'd0, 20'd1, 20'd2, 20'd20,
			20'd21, 20'd22, 20'd9, 20'd9));
		send(elem(KIND_OTHER, 4'd4, 20'd3, 20'd2, 20'd1, 20'd0,
			VID_MAX, VID_MAX, VID_MAX, VID_MAX));
		send(elem(KIND_ODD, 4'd15, 20'd10, 20'd11, 20'd12, 20'd13,
			20'd20, 20'd21, 20'd22, 20'd23));
		send(elem(KIND_OTHER, 4'd0, 20'd20, 20'd21, 20'd22, 20'd0,
			20'd0, 20'd0, 20'd0, 20'd0));
		for (int i = 0; i < 7; i++) send(ask(i));
		send(ask(1023));
		send(plain(OP_UNUSED));
		// inner_count as large as the store: every loaded element is inner
		write_inner(11'd1024);
		send(ask(4));
		send(ask(5));
		send(ask(6));
		send(plain(OP_CLEAR));
		send(ask(0));
		write_inner(11'd0);
		send(ask(0));

		// Random phases: a fresh mesh per phase, then queries into it
		while (queries_sent + loads_sent < 70) begin
			phases++;
			burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 12; i++)
				pool[i] = ($urandom_range(0, 5) == 0) ? VID_MAX - VID_W'(i)
					: VID_W'($urandom_range(0, 40));
			n_elems = $urandom_range(3, 12);
			r = $urandom_range(0, 9);
			if (r == 0) write_inner(INNER_W'($urandom_range(0, 2047)));
			else if (r == 1) write_inner(11'd0);
			else write_inner(INNER_W'($urandom_range(1, n_elems)));
			send(plain(OP_CLEAR));
			for (int i = 0; i < n_elems; i++) begin
				r = $urandom_range(0, 9);
				if (i < sb.inner_cnt && r < 8)
					send(pool_elem(r[0] ? KIND_PRISM : KIND_HEX));
				else if (i > 0 && r < 7)
					send(face_elem($urandom_range(0, i - 1)));
				else begin
					it = rand_item();
					it.operation = OP_LOAD;
					if (r == 9) it.vertex_a = pick();
					send(it);
				end
			end
			n_q = $urandom_range(3, 7);
			for (int i = 0; i < n_q; i++) begin
				if ($urandom_range(0, 12) == 0) send(plain(OP_UNUSED));
				send(ask($urandom_range(0, n_elems + 1)));
			end
		end

		burst = 0;
		settle();
		$display("Covered %0d loads and %0d queries over %0d random mesh phases,",
			loads_sent, queries_sent, phases);
		$display("%0d results compared, with stalls on both sides and back-to-back bursts.",
			sb.checked);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#50_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
